[rtl/core/cl4_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cl4_pkg: shared types and microcode for the 4-bit LCD command sequencer
// Holds the control word layout, the wait table and the step program.
// ---------------------------------------------------------------------------
package cl4_pkg;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 6;
   localparam int NIB_W    = 4;
   localparam int WAIT_W   = 15;
   localparam int STEP_W   = 5;

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_INIT  = 2'd0,
      MODE_PUT   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_GOTO  = 2'd3
   } mode_type;

   // Byte constants
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CMD_ROW1     = 8'h80 | (8'd1 << 6);
   localparam logic [CHAR_W-1:0] CMD_GOTO     = 8'h80;
   localparam logic [COL_W-1:0]  COL_MASK     = 6'h2f;

   // Wait times in microseconds
   localparam int BYTE_WAIT_US   = 40 + 20;
   localparam int CLEAR_EXTRA_US = (2 + 1) * 1000;

   typedef enum logic [2:0] {
      WAIT_NONE,
      WAIT_BYTE,
      WAIT_NIB2,
      WAIT_NIB3,
      WAIT_CLEAR,
      WAIT_NIB3_LONG,
      WAIT_POWER
   } wait_code_type;

   // Nibble source of one step
   typedef enum logic [1:0] {
      NIB_CONST,
      NIB_OP_HI,
      NIB_OP_LO
   } nib_src_type;

   typedef struct packed {
      nib_src_type        nib_src;
      logic [NIB_W-1:0]   nib_const;
      logic               rs_op;
      logic               strobe;
      wait_code_type      wait_code;
      logic               last;
   } ctrl_word_type;

   // Program entry points
   localparam logic [STEP_W-1:0] ENTRY_INIT  = 5'd0;
   localparam logic [STEP_W-1:0] ENTRY_BYTE  = 5'd13;
   localparam logic [STEP_W-1:0] ENTRY_CLEAR = 5'd15;
   localparam logic [STEP_W-1:0] LAST_STEP   = 5'd17;

   function automatic logic [WAIT_W-1:0] wait_value(input wait_code_type code);
      logic [WAIT_W-1:0] v;
      case (code)
         WAIT_NONE:      v = '0;
         WAIT_BYTE:      v = WAIT_W'(BYTE_WAIT_US);
         WAIT_NIB2:      v = WAIT_W'(40 + 60);
         WAIT_NIB3:      v = WAIT_W'(100 + 5);
         WAIT_CLEAR:     v = WAIT_W'(BYTE_WAIT_US + CLEAR_EXTRA_US);
         WAIT_NIB3_LONG: v = WAIT_W'((5 + 2) * 1000);
         WAIT_POWER:     v = WAIT_W'((15 + 5) * 1000);
         default:        v = '0;
      endcase
      return v;
   endfunction

   function automatic ctrl_word_type cw(input nib_src_type src,
                                        input logic [NIB_W-1:0] nib,
                                        input logic rs, input logic stb,
                                        input wait_code_type wc, input logic lst);
      ctrl_word_type w;
      w.nib_src   = src;
      w.nib_const = nib;
      w.rs_op     = rs;
      w.strobe    = stb;
      w.wait_code = wc;
      w.last      = lst;
      return w;
   endfunction

   // Step program: init, shared byte send, clear
   function automatic ctrl_word_type program_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         5'd0:    w = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, WAIT_POWER,     1'b0);
         5'd1:    w = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, WAIT_NIB3_LONG, 1'b0);
         5'd2:    w = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, WAIT_NIB3,      1'b0);
         5'd3:    w = cw(NIB_CONST, 4'h3, 1'b0, 1'b1, WAIT_NIB3_LONG, 1'b0);
         5'd4:    w = cw(NIB_CONST, 4'h2, 1'b0, 1'b1, WAIT_NIB2,      1'b0);
         5'd5:    w = cw(NIB_CONST, 4'h2, 1'b0, 1'b1, WAIT_NONE,      1'b0);
         5'd6:    w = cw(NIB_CONST, 4'hC, 1'b0, 1'b1, WAIT_BYTE,      1'b0);
         5'd7:    w = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, WAIT_NONE,      1'b0);
         5'd8:    w = cw(NIB_CONST, 4'hC, 1'b0, 1'b1, WAIT_BYTE,      1'b0);
         5'd9:    w = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, WAIT_NONE,      1'b0);
         5'd10:   w = cw(NIB_CONST, 4'h6, 1'b0, 1'b1, WAIT_BYTE,      1'b0);
         5'd11:   w = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, WAIT_NONE,      1'b0);
         5'd12:   w = cw(NIB_CONST, 4'h1, 1'b0, 1'b1, WAIT_CLEAR,     1'b1);
         5'd13:   w = cw(NIB_OP_HI, 4'h0, 1'b1, 1'b1, WAIT_NONE,      1'b0);
         5'd14:   w = cw(NIB_OP_LO, 4'h0, 1'b1, 1'b1, WAIT_BYTE,      1'b1);
         5'd15:   w = cw(NIB_CONST, 4'h0, 1'b0, 1'b1, WAIT_NONE,      1'b0);
         5'd16:   w = cw(NIB_CONST, 4'h1, 1'b0, 1'b1, WAIT_CLEAR,     1'b0);
         5'd17:   w = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, WAIT_NONE,      1'b1);
         default: w = cw(NIB_CONST, 4'h0, 1'b0, 1'b0, WAIT_NONE,      1'b1);
      endcase
      return w;
   endfunction

endpackage

[rtl/core/cl4_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cl4_if: request and event channels of the LCD command sequencer
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface cl4_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] character;
   logic       row;
   logic [5:0] column;

   modport source (output valid, output mode, output character, output row,
                   output column, input ready);
   modport sink   (input valid, input mode, input character, input row,
                   input column, output ready);
endinterface

interface cl4_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic [3:0]  nibble;
   logic        strobe_res;
   logic [14:0] wait_us;
   logic        last;

   modport source (output valid, output reg_select, output nibble, output strobe_res,
                   output wait_us, output last, input ready);
   modport sink   (input valid, input reg_select, input nibble, input strobe_res,
                   input wait_us, input last, output ready);
endinterface

[rtl/core/char_lcd_4bit_command_sequencer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer: request to LCD pin event sequencer
// Runs a small step program that expands each request into timed events.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  ---------+-----+----------------------------------------------+-----------
//  req_ch   | in  | mode, character, row, column                 | valid/ready
//  rsp_ch   | out | reg_select, nibble, strobe_res, wait_us, last| valid/ready
//
//  A request of N events (init 13, clear 3, put and goto 2) is run by loading
//  the step counter, then moving one event per cycle, unless the output is
//  stalled, out of the program table into the output register.
//  Synchronous active-high reset clears the busy flag and the output valid.
//  A stalled event holds the step counter; the next request is taken once
//  the final event of the current one sits in the output register.
// ---------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer (
   input logic      clock,
   input logic      reset,
   cl4_req_if.sink   req_ch,
   cl4_rsp_if.source rsp_ch
);
   import cl4_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CHAR_W-1:0]   op_byte_ff, op_byte_in;
   logic                op_rs_ff, op_rs_in;

   logic                rsp_valid_ff;
   logic                rsp_rs_ff;
   logic [NIB_W-1:0]    rsp_nib_ff;
   logic                rsp_strobe_ff;
   logic [WAIT_W-1:0]   rsp_wait_ff;
   logic                rsp_last_ff;

   logic                req_fire;
   logic                step_fire;
   ctrl_word_type       word;
   logic [NIB_W-1:0]    nib_sel;
   logic [STEP_W-1:0]   entry;

   assign req_ch.ready = !busy_ff;
   assign req_fire     = req_ch.valid && !busy_ff;
   assign step_fire    = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign word         = program_word(step_ff);

   // Pick program entry and operand byte for the request
   always_comb begin
      entry      = ENTRY_BYTE;
      op_byte_in = op_byte_ff;
      op_rs_in   = op_rs_ff;
      case (mode_type'(req_ch.mode))
         MODE_INIT: begin
            entry = ENTRY_INIT;
         end
         MODE_PUT: begin
            if (req_ch.character == CHAR_NEWLINE) begin
               op_byte_in = CMD_ROW1;
               op_rs_in   = 1'b0;
            end else begin
               op_byte_in = req_ch.character;
               op_rs_in   = 1'b1;
            end
         end
         MODE_CLEAR: begin
            entry = ENTRY_CLEAR;
         end
         MODE_GOTO: begin
            op_byte_in = CMD_GOTO | {1'b0, req_ch.row, 6'(req_ch.column & COL_MASK)};
            op_rs_in   = 1'b0;
         end
         default: begin
            entry = ENTRY_INIT;
         end
      endcase
   end

   // Select the nibble the current step drives
   always_comb begin
      case (word.nib_src)
         NIB_CONST: nib_sel = word.nib_const;
         NIB_OP_HI: nib_sel = op_byte_ff[CHAR_W-1:NIB_W];
         NIB_OP_LO: nib_sel = op_byte_ff[NIB_W-1:0];
         default:   nib_sel = word.nib_const;
      endcase
   end

   // Advance the step counter; drop busy after the final step
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = entry;
      end else if (step_fire) begin
         step_in = step_ff + 1'b1;
         if (word.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      if (req_fire) begin
         op_byte_ff <= op_byte_in;
         op_rs_ff   <= op_rs_in;
      end
   end

   // Output register: load one event per step, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_fire) begin
         rsp_rs_ff     <= word.rs_op & op_rs_ff;
         rsp_nib_ff    <= nib_sel;
         rsp_strobe_ff <= word.strobe;
         rsp_wait_ff   <= wait_value(word.wait_code);
         rsp_last_ff   <= word.last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.reg_select = rsp_rs_ff;
   assign rsp_ch.nibble     = rsp_nib_ff;
   assign rsp_ch.strobe_res = rsp_strobe_ff;
   assign rsp_ch.wait_us    = rsp_wait_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // Checks on the sequencer
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (busy_ff && (step_ff == ENTRY_INIT || step_ff == ENTRY_BYTE
                                || step_ff == ENTRY_CLEAR)))
      else $error("request accept did not load a program entry");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= LAST_STEP))
      else $error("step counter ran past the program");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step_fire && word.last) |=> (!busy_ff && rsp_valid_ff && rsp_last_ff))
      else $error("final step did not end the request");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !word.last) |=> (busy_ff && !rsp_last_ff))
      else $error("request ended before its final step");

endmodule

[bench/char_lcd_4bit_command_sequencer_check.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_check: pin event predictor and comparator
// Watches the request and event channels, expands each accepted request into
// the pin events it must produce, and compares every accepted event in order.
// ---------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_check (
   input  logic clock,
   input  logic reset,
   cl4_req_if   req_mon,
   cl4_rsp_if   rsp_mon,
   output int   error_count,
   output int   events_due
);
   import cl4_pkg::*;

   // Fixed delays of the power-up handshake, in microseconds
   localparam int POWER_UP_US   = (15 + 5) * 1000;
   localparam int NIB3_LONG_US  = (5 + 2) * 1000;
   localparam int NIB3_SHORT_US = 100 + 5;
   localparam int NIB2_US       = 40 + 60;

   localparam logic [NIB_W-1:0] NIB_8BIT_MODE = 4'h3;
   localparam logic [NIB_W-1:0] NIB_4BIT_MODE = 4'h2;
   localparam logic [CHAR_W-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [CHAR_W-1:0] SETUP_BYTES [4] = '{8'h2C, 8'h0C, 8'h06, 8'h01};

   typedef struct packed {
      logic               reg_select;
      logic [NIB_W-1:0]   nibble;
      logic               strobe_res;
      logic [WAIT_W-1:0]  wait_us;
      logic               last;
   } pin_event_type;

   pin_event_type pin_events_due[$];
   int            mismatches = 0;

   function automatic void add_event(input logic rs, input logic [NIB_W-1:0] nib,
                                     input logic stb, input int wait_time,
                                     input logic fin);
      pin_event_type ev;
      ev.reg_select = rs;
      ev.nibble     = nib;
      ev.strobe_res = stb;
      ev.wait_us    = WAIT_W'(wait_time);
      ev.last       = fin;
      pin_events_due.push_back(ev);
   endfunction

   // A byte goes out high nibble first; only the low nibble carries the settle wait
   function automatic void add_byte(input logic rs, input logic [CHAR_W-1:0] data,
                                    input int extra_us, input logic fin);
      add_event(rs, data[7:4], 1'b1, 0, 1'b0);
      add_event(rs, data[3:0], 1'b1, BYTE_WAIT_US + extra_us, fin);
   endfunction

   function automatic void expand_request(input mode_type mode,
                                          input logic [CHAR_W-1:0] character,
                                          input logic row,
                                          input logic [COL_W-1:0] column);
      logic [CHAR_W-1:0] position;
      case (mode)
         MODE_INIT: begin
            add_event(1'b0, 4'h0, 1'b0, POWER_UP_US, 1'b0);
            add_event(1'b0, NIB_8BIT_MODE, 1'b1, NIB3_LONG_US, 1'b0);
            add_event(1'b0, NIB_8BIT_MODE, 1'b1, NIB3_SHORT_US, 1'b0);
            add_event(1'b0, NIB_8BIT_MODE, 1'b1, NIB3_LONG_US, 1'b0);
            add_event(1'b0, NIB_4BIT_MODE, 1'b1, NIB2_US, 1'b0);
            for (int i = 0; i < 3; i++) begin
               add_byte(1'b0, SETUP_BYTES[i], 0, 1'b0);
            end
            // fold the clear delay into the final setup byte
            add_byte(1'b0, SETUP_BYTES[3], CLEAR_EXTRA_US, 1'b1);
         end
         MODE_PUT: begin
            if (character == CHAR_NEWLINE) begin
               add_byte(1'b0, CMD_ROW1, 0, 1'b1);
            end else begin
               add_byte(1'b1, character, 0, 1'b1);
            end
         end
         MODE_CLEAR: begin
            add_byte(1'b0, CMD_CLEAR, CLEAR_EXTRA_US, 1'b0);
            add_event(1'b0, 4'h0, 1'b0, 0, 1'b1);
         end
         default: begin
            position = CMD_GOTO | (CHAR_W'(row) << 6) | CHAR_W'(column & COL_MASK);
            add_byte(1'b0, position, 0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned expd,
                                       input int unsigned actv);
      if (expd != actv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd,
                  actv);
         mismatches++;
      end
   endfunction

   // Predict on each request transaction, compare on each event transaction
   always @(posedge clock) begin
      pin_event_type want;
      pin_event_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            expand_request(mode_type'(req_mon.mode), req_mon.character, req_mon.row,
                           req_mon.column);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.reg_select = rsp_mon.reg_select;
            got.nibble     = rsp_mon.nibble;
            got.strobe_res = rsp_mon.strobe_res;
            got.wait_us    = rsp_mon.wait_us;
            got.last       = rsp_mon.last;
            if (pin_events_due.size() == 0) begin
               $display({"%0t: unexpected event, expected none, ",
                         "actual rs=%0d nib=%0h stb=%0d wait=%0d last=%0d"},
                        $time, got.reg_select, got.nibble, got.strobe_res,
                        got.wait_us, got.last);
               mismatches++;
            end else begin
               want = pin_events_due.pop_front();
               check_field("reg_select", want.reg_select, got.reg_select);
               check_field("nibble", want.nibble, got.nibble);
               check_field("strobe_res", want.strobe_res, got.strobe_res);
               check_field("wait_us", want.wait_us, got.wait_us);
               check_field("last", want.last, got.last);
            end
         end
      end
      error_count <= mismatches;
      events_due  <= pin_events_due.size();
   end

endmodule

[bench/char_lcd_4bit_command_sequencer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_tb: stimulus and verdict for the sequencer
// Drives directed and random requests in bursts against a stalling event
// receiver; the checker beside the block predicts and compares every event.
// ---------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_tb;
   import cl4_pkg::*;

   localparam int RANDOM_REQUESTS = 350;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 20;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   events_due;
   int   burst_left = 0;
   logic [8:0] stall_phase = '0;

   cl4_req_if req_ch ();
   cl4_rsp_if rsp_ch ();

   char_lcd_4bit_command_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   char_lcd_4bit_command_sequencer_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .error_count (error_count),
      .events_due  (events_due)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the event receiver on a rotating pattern: open, coin flip, sparse, periodic
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[8:7])
         2'd0: begin
            rsp_ch.ready <= 1'b1;
         end
         2'd1: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end
         2'd2: begin
            rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ch.ready <= (stall_phase[2:0] != 3'd5);
         end
      endcase
   end

   // Present one request and hold it until the transaction completes
   task automatic send_request(input mode_type mode, input logic [CHAR_W-1:0] character,
                               input logic row, input logic [COL_W-1:0] column);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.character <= character;
      req_ch.row       <= row;
      req_ch.column    <= column;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      burst_left--;
   endtask

   // Drop valid and hold off until every predicted event has come out
   task automatic drain_events();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (events_due != 0);
   endtask

   // Watchdog: end the run if no transaction moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("char_lcd_4bit_command_sequencer_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int        pick;
      mode_type  mode;
      logic [CHAR_W-1:0] character;

      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_INIT;
      req_ch.character = '0;
      req_ch.row       = 1'b0;
      req_ch.column    = '0;
      reset            = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every mode, byte extremes, newline, column folding
      send_request(MODE_INIT, 8'h00, 1'b0, 6'd0);
      send_request(MODE_PUT, 8'h00, 1'b0, 6'd0);
      send_request(MODE_PUT, 8'hFF, 1'b1, 6'd63);
      send_request(MODE_PUT, CHAR_NEWLINE, 1'b0, 6'd0);
      send_request(MODE_PUT, 8'h09, 1'b0, 6'd0);
      send_request(MODE_PUT, 8'h0B, 1'b0, 6'd0);
      send_request(MODE_PUT, 8'h41, 1'b0, 6'd0);
      send_request(MODE_CLEAR, 8'hA5, 1'b1, 6'd21);
      send_request(MODE_GOTO, 8'h00, 1'b0, 6'd0);
      send_request(MODE_GOTO, 8'hFF, 1'b1, 6'd63);
      send_request(MODE_GOTO, 8'h00, 1'b0, 6'd16);
      send_request(MODE_GOTO, 8'h00, 1'b1, 6'd31);
      send_request(MODE_GOTO, 8'h00, 1'b0, 6'd47);
      send_request(MODE_GOTO, 8'h00, 1'b1, 6'd32);
      send_request(MODE_GOTO, 8'h00, 1'b1, 6'd15);
      send_request(MODE_CLEAR, 8'h00, 1'b0, 6'd0);
      send_request(MODE_INIT, 8'hFF, 1'b1, 6'd63);
      drain_events();

      // Random: characters most often, with init, clear and goto mixed in
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            mode = MODE_INIT;
         end else if (pick < 55) begin
            mode = MODE_PUT;
         end else if (pick < 70) begin
            mode = MODE_CLEAR;
         end else begin
            mode = MODE_GOTO;
         end
         character = ($urandom_range(0, 9) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
         send_request(mode, character, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
         if (i % 70 == 69) begin
            drain_events();
         end
      end

      // Wait out the remaining events, then give the verdict
      drain_events();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && events_due == 0) begin
         $display("char_lcd_4bit_command_sequencer_tb: PASS");
      end else begin
         $display("char_lcd_4bit_command_sequencer_tb: FAIL");
      end
      $finish;
   end

endmodule
